>>> rtl/iol_pkg.sv
package iol_pkg;

	// list geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths
	localparam int DATA_W = 32;
	localparam int POS_W  = 16;
	localparam int LEN_W  = 7;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int CMP_W  = POS_W + 1;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ     = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

	// status codes
	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	// per-cycle shift action of the cell row
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INSERT,
		SH_DELETE
	} shift_t;

	// command broadcast to every cell
	typedef struct packed {
		shift_t            mode;
		logic [IDX_W-1:0]  where;
		logic [IDX_W-1:0]  rd_idx;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

>>> rtl/indexed_ordered_list_unit.sv
// indexed ordered list, one element per cell in a shifting row
// the result is registered and presented in the cycle after the input transfer
// throughput: one operation per cycle while m_tready does not stall the output; the whole row shifts together
// reset: arst_n clears the element count and the output valid; element cells are
// not cleared and are only read after they were written
module indexed_ordered_list_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // position[15:0], value[47:16]
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_data[31:0], length[38:32], zero[39]
	output logic [2:0]  m_tuser    // hit[0], status[2:1]
);

	logic                               accept;
	logic [iol_pkg::OP_W-1:0]           op;
	logic signed [iol_pkg::POS_W-1:0]   position;
	logic [iol_pkg::DATA_W-1:0]         value;
	logic signed [iol_pkg::CMP_W-1:0]   pos_s;
	logic signed [iol_pkg::CMP_W-1:0]   len_s;
	logic                               in_list;
	logic                               full;
	logic [iol_pkg::CNT_W-1:0]          count_q;
	logic [iol_pkg::CNT_W-1:0]          count_d;
	iol_pkg::cell_cmd_t                 cmd;
	logic [iol_pkg::DATA_W-1:0]         chain_rd;
	logic                               is_read;
	logic                               hit_d;
	logic [iol_pkg::ST_W-1:0]           status_d;
	logic                               valid_q;
	logic [iol_pkg::DATA_W-1:0]         read_data_q;
	logic                               hit_q;
	logic [iol_pkg::ST_W-1:0]           status_q;
	logic [iol_pkg::LEN_W-1:0]          length_q;

	// unpack input transfer
	assign op       = s_tuser;
	assign position = s_tdata[15:0];
	assign value    = s_tdata[47:16];

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// range checks against the current length
	assign pos_s   = iol_pkg::CMP_W'(position);
	assign len_s   = $signed({{(iol_pkg::CMP_W - iol_pkg::CNT_W){1'b0}}, count_q});
	assign in_list = (pos_s >= 0) && (pos_s < len_s);
	assign full    = count_q == iol_pkg::CNT_W'(iol_pkg::CAPACITY);

	// decode operation into a row command and a result
	always_comb begin
		cmd.mode   = iol_pkg::SH_HOLD;
		cmd.where  = '0;
		cmd.rd_idx = position[iol_pkg::IDX_W-1:0];
		cmd.value  = value;
		count_d    = count_q;
		status_d   = iol_pkg::ST_DONE;
		hit_d      = 1'b0;
		is_read    = 1'b0;
		case (op)
			iol_pkg::OP_READ: begin
				is_read = 1'b1;
				if (in_list) begin
					hit_d = 1'b1;
				end else begin
					status_d = iol_pkg::ST_IGNORED;
				end
			end
			iol_pkg::OP_INS_HEAD: begin
				if (full) begin
					status_d = iol_pkg::ST_FULL;
				end else begin
					cmd.mode = iol_pkg::SH_INSERT;
					count_d  = count_q + iol_pkg::CNT_W'(1);
				end
			end
			iol_pkg::OP_INS_TAIL: begin
				if (full) begin
					status_d = iol_pkg::ST_FULL;
				end else begin
					cmd.mode  = iol_pkg::SH_INSERT;
					cmd.where = count_q[iol_pkg::IDX_W-1:0];
					count_d   = count_q + iol_pkg::CNT_W'(1);
				end
			end
			iol_pkg::OP_INS_AT: begin
				if (pos_s > len_s) begin
					status_d = iol_pkg::ST_IGNORED;
				end else if (full) begin
					status_d = iol_pkg::ST_FULL;
				end else begin
					cmd.mode = iol_pkg::SH_INSERT;
					if (pos_s > 0) begin
						cmd.where = position[iol_pkg::IDX_W-1:0];
					end
					count_d = count_q + iol_pkg::CNT_W'(1);
				end
			end
			iol_pkg::OP_DELETE: begin
				if (in_list) begin
					cmd.mode  = iol_pkg::SH_DELETE;
					cmd.where = position[iol_pkg::IDX_W-1:0];
					count_d   = count_q - iol_pkg::CNT_W'(1);
				end else begin
					status_d = iol_pkg::ST_IGNORED;
				end
			end
			default: begin
				status_d = iol_pkg::ST_IGNORED;
			end
		endcase
		if (!accept) begin
			cmd.mode = iol_pkg::SH_HOLD;
		end
	end

	iol_chain u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.rd_data (chain_rd)
	);

	// element count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			if (hit_d) begin
				read_data_q <= chain_rd;
			end else if (is_read) begin
				read_data_q <= '1;
			end else begin
				read_data_q <= '0;
			end
			hit_q    <= hit_d;
			status_q <= status_d;
			length_q <= iol_pkg::LEN_W'(count_d);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, length_q, read_data_q};
	assign m_tuser  = {status_q, hit_q};

endmodule

>>> rtl/iol_cell.sv
module iol_cell (
	input  logic                        clk,
	input  iol_pkg::cell_cmd_t          cmd,
	input  logic [iol_pkg::IDX_W-1:0]   idx,
	input  logic [iol_pkg::DATA_W-1:0]  left_data,
	input  logic [iol_pkg::DATA_W-1:0]  right_data,
	output logic [iol_pkg::DATA_W-1:0]  data,
	output logic [iol_pkg::DATA_W-1:0]  rd_data
);

	logic [iol_pkg::DATA_W-1:0] data_q;

	// element register: hold, take neighbor or take new value
	always_ff @(posedge clk) begin
		case (cmd.mode)
			iol_pkg::SH_INSERT: begin
				if (idx == cmd.where) begin
					data_q <= cmd.value;
				end else if (idx > cmd.where) begin
					data_q <= left_data;
				end
			end
			iol_pkg::SH_DELETE: begin
				if (idx >= cmd.where) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

	// gated contribution to the read reduction
	assign rd_data = (idx == cmd.rd_idx) ? data_q : '0;

endmodule

>>> rtl/iol_chain.sv
module iol_chain (
	input  logic                        clk,
	input  iol_pkg::cell_cmd_t          cmd,
	output logic [iol_pkg::DATA_W-1:0]  rd_data
);

	logic [iol_pkg::DATA_W-1:0] data_w [iol_pkg::CAPACITY];
	logic [iol_pkg::DATA_W-1:0] gated_w [iol_pkg::CAPACITY];

	// row of cells, each linked to both neighbors
	for (genvar i = 0; i < iol_pkg::CAPACITY; i++) begin : g_cell
		logic [iol_pkg::DATA_W-1:0] left_w;
		logic [iol_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = data_w[i];
		end else begin : g_left
			assign left_w = data_w[i-1];
		end

		if (i == iol_pkg::CAPACITY - 1) begin : g_last
			assign right_w = data_w[i];
		end else begin : g_right
			assign right_w = data_w[i+1];
		end

		iol_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (iol_pkg::IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (data_w[i]),
			.rd_data    (gated_w[i])
		);
	end

	// or-reduce the one selected cell
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < iol_pkg::CAPACITY; i++) begin
			rd_data = rd_data | gated_w[i];
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int RANDOM_OPS  = 1625;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 300;

	// one list operation as it travels on the slave side
	typedef struct packed {
		logic [iol_pkg::OP_W-1:0]          op;
		logic signed [iol_pkg::POS_W-1:0]  pos;
		logic [iol_pkg::DATA_W-1:0]        val;
	} list_op_t;

	// what the list should answer for one operation
	typedef struct packed {
		logic [iol_pkg::DATA_W-1:0] read_data;
		logic                       hit;
		logic [iol_pkg::ST_W-1:0]   status;
		logic [iol_pkg::LEN_W-1:0]  length;
	} list_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // position[15:0], value[47:16]
	logic [2:0]  s_tuser = '0;   // op[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // read_data[31:0], length[38:32], zero[39]
	logic [2:0]  m_tuser;        // hit[0], status[2:1]

	list_op_t     op_queue[$];
	list_answer_t answer_q[$];
	list_answer_t want;

	// shadow copy of the list contents
	logic [iol_pkg::DATA_W-1:0] list_elem[iol_pkg::CAPACITY];
	int                         list_len = 0;

	int gen_len = 0;
	int send_gap = 0;
	int ready_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int results_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit quiet;

	indexed_ordered_list_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// stretches with no idling at all on either side
	assign quiet = (cycle_count % 2000) < 400;

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// open a slot at index where and shift the tail up by one
	task automatic place_elem(input int where, input logic [iol_pkg::DATA_W-1:0] val);
		for (int i = list_len; i > where; i--)
			list_elem[i] = list_elem[i - 1];
		list_elem[where] = val;
		list_len++;
	endtask

	// apply one operation to the shadow list and queue the answer
	task automatic apply_list_op(input list_op_t item);
		list_answer_t ans;
		int           p;
		bit           full;
		ans = '0;
		p = item.pos;
		full = list_len >= iol_pkg::CAPACITY;
		case (item.op)
			iol_pkg::OP_READ: begin
				if (p >= 0 && p < list_len) begin
					ans.read_data = list_elem[p];
					ans.hit = 1'b1;
				end else begin
					ans.read_data = '1;
					ans.status = iol_pkg::ST_IGNORED;
				end
			end
			iol_pkg::OP_INS_HEAD: begin
				if (full)
					ans.status = iol_pkg::ST_FULL;
				else
					place_elem(0, item.val);
			end
			iol_pkg::OP_INS_TAIL: begin
				if (full)
					ans.status = iol_pkg::ST_FULL;
				else
					place_elem(list_len, item.val);
			end
			iol_pkg::OP_INS_AT: begin
				// out of range is checked ahead of full
				if (p > list_len)
					ans.status = iol_pkg::ST_IGNORED;
				else if (full)
					ans.status = iol_pkg::ST_FULL;
				else
					place_elem((p <= 0) ? 0 : p, item.val);
			end
			iol_pkg::OP_DELETE: begin
				if (p >= 0 && p < list_len) begin
					for (int i = p; i + 1 < list_len; i++)
						list_elem[i] = list_elem[i + 1];
					list_len--;
				end else begin
					ans.status = iol_pkg::ST_IGNORED;
				end
			end
			default: ans.status = iol_pkg::ST_IGNORED;
		endcase
		ans.length = list_len[iol_pkg::LEN_W-1:0];
		answer_q.push_back(ans);
	endtask

	// queue an operation and follow the list length it leads to
	task automatic queue_op(input logic [iol_pkg::OP_W-1:0] op, input int pos,
			input logic [iol_pkg::DATA_W-1:0] val);
		list_op_t item;
		int       p;
		item.op = op;
		item.pos = pos[iol_pkg::POS_W-1:0];
		item.val = val;
		p = item.pos;
		op_queue.push_back(item);
		case (op)
			iol_pkg::OP_INS_HEAD, iol_pkg::OP_INS_TAIL:
				if (gen_len < iol_pkg::CAPACITY) gen_len++;
			iol_pkg::OP_INS_AT:
				if (p <= gen_len && gen_len < iol_pkg::CAPACITY) gen_len++;
			iol_pkg::OP_DELETE:
				if (p >= 0 && p < gen_len) gen_len--;
			default: ;
		endcase
	endtask

	function automatic logic [iol_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 39))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, gen_len);
		else if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return -1;
				1: return 0;
				2: return gen_len;
				default: return gen_len + 1;
			endcase
		end else
			return $urandom_range(0, 65535);
	endfunction

	// weighted choice of operation for the current trend
	function automatic logic [iol_pkg::OP_W-1:0] pick_op(input int trend);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return iol_pkg::OP_W'($urandom_range(5, 7));
		case (trend)
			0: begin
				// growing
				if (r < 17) return iol_pkg::OP_READ;
				if (r < 37) return iol_pkg::OP_INS_HEAD;
				if (r < 57) return iol_pkg::OP_INS_TAIL;
				if (r < 87) return iol_pkg::OP_INS_AT;
				return iol_pkg::OP_DELETE;
			end
			1: begin
				// shrinking
				if (r < 17) return iol_pkg::OP_READ;
				if (r < 22) return iol_pkg::OP_INS_HEAD;
				if (r < 27) return iol_pkg::OP_INS_TAIL;
				if (r < 37) return iol_pkg::OP_INS_AT;
				return iol_pkg::OP_DELETE;
			end
			default: begin
				if (r < 27) return iol_pkg::OP_READ;
				if (r < 42) return iol_pkg::OP_INS_HEAD;
				if (r < 57) return iol_pkg::OP_INS_TAIL;
				if (r < 77) return iol_pkg::OP_INS_AT;
				return iol_pkg::OP_DELETE;
			end
		endcase
	endfunction

	// stimulus, reset and end of run
	initial begin
		int left;
		int span;
		int trend;
		int total_ops;

		// directed: empty list, boundaries, value extremes, unused codes
		queue_op(iol_pkg::OP_READ, 0, 32'h0);
		queue_op(iol_pkg::OP_DELETE, 0, 32'h0);
		queue_op(iol_pkg::OP_INS_AT, 1, 32'h1234_5678);
		queue_op(iol_pkg::OP_INS_AT, 0, 32'h7FFF_FFFF);
		queue_op(iol_pkg::OP_INS_HEAD, 0, 32'h8000_0000);
		queue_op(iol_pkg::OP_INS_TAIL, 0, 32'hFFFF_FFFF);
		queue_op(iol_pkg::OP_INS_AT, -32768, 32'h0000_0000);
		queue_op(iol_pkg::OP_INS_AT, 4, 32'h0000_0001);
		queue_op(iol_pkg::OP_INS_AT, 32767, 32'hDEAD_BEEF);
		queue_op(iol_pkg::OP_INS_AT, 2, 32'h5A5A_5A5A);
		queue_op(iol_pkg::OP_READ, -1, 32'h0);
		queue_op(iol_pkg::OP_READ, -32768, 32'h0);
		queue_op(iol_pkg::OP_READ, 6, 32'h0);
		queue_op(iol_pkg::OP_READ, 0, 32'h0);
		queue_op(iol_pkg::OP_READ, 5, 32'h0);
		queue_op(iol_pkg::OP_READ, 2, 32'h0);
		queue_op(iol_pkg::OP_DELETE, -1, 32'h0);
		queue_op(iol_pkg::OP_DELETE, 6, 32'h0);
		queue_op(iol_pkg::OP_DELETE, 32767, 32'h0);
		queue_op(iol_pkg::OP_DELETE, 0, 32'h0);
		queue_op(iol_pkg::OP_DELETE, 4, 32'h0);
		queue_op(3'd5, 0, 32'hFFFF_FFFF);
		queue_op(3'd6, -1, 32'h0);
		queue_op(3'd7, 65535, 32'hFFFF_FFFF);
		queue_op(iol_pkg::OP_DELETE, 1, 32'h0);

		// random: runs that drift the length up, down or around, first one filling
		left = RANDOM_OPS;
		trend = 0;
		while (left > 0) begin
			span = $urandom_range(80, 160);
			if (span > left)
				span = left;
			for (int i = 0; i < span; i++)
				queue_op(pick_op(trend), pick_position(), pick_value());
			left -= span;
			trend = $urandom_range(0, 2);
		end
		total_ops = op_queue.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// every operation gives exactly one result transfer
		while (results_seen < total_ops) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// driver: predict on each input transfer, then offer the next operation
	always @(posedge clk or negedge arst_n) begin
		list_op_t next_op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_list_op('{op: s_tuser, pos: s_tdata[15:0], val: s_tdata[47:16]});
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (op_queue.size() != 0) begin
					next_op = op_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_op.val, next_op.pos};
					s_tuser <= next_op.op;
					send_gap <= pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output transfer and drive the ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (answer_q.size() == 0) begin
					$error("result transfer with no operation outstanding");
					fail_count++;
				end else begin
					want = answer_q.pop_front();
					if (m_tdata[31:0] !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, m_tdata[31:0]);
						fail_count++;
					end
					if (m_tuser[0] !== want.hit) begin
						$error("hit: expected %b, got %b", want.hit, m_tuser[0]);
						fail_count++;
					end
					if (m_tuser[2:1] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
						fail_count++;
					end
					if (m_tdata[38:32] !== want.length) begin
						$error("length: expected %0d, got %0d", want.length, m_tdata[38:32]);
						fail_count++;
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (ready_gap != 0) begin
				ready_gap <= ready_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				ready_gap <= pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one long receiver hold-off so the list backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
